### sv/ssw_pkg.sv
package ssw_pkg;

  localparam int NumW      = 16;
  localparam int ValW      = 14;
  localparam int QuotW     = 10;
  localparam int DigitW    = 4;
  localparam int PosW      = 2;
  localparam int FrameW    = 16;
  localparam int BitCntW   = 4;
  localparam int RecipW    = 16;
  localparam int RecipSh   = 19;
  localparam int ProdW     = ValW + RecipW;

  localparam logic [NumW-1:0]   NUM_MAX    = 16'd9999;
  localparam logic [RecipW-1:0] RECIP_10   = 16'd52429;
  localparam logic [PosW-1:0]   POS_UNITS  = 2'd3;
  localparam logic [BitCntW-1:0] BIT_LAST  = 4'd15;

  typedef logic [ValW-1:0]   val_t;
  typedef logic [QuotW-1:0]  quot_t;
  typedef logic [DigitW-1:0] digit_t;
  typedef logic [PosW-1:0]   pos_t;

  // one frame handed from the sequencer to the shifter
  typedef struct packed {
    logic              load;
    logic [FrameW-1:0] bits;
    pos_t              pos;
    logic              last;
  } ssw_frame_t;

  // active-low segment pattern
  function automatic logic [7:0] seg_of(input digit_t d);
    logic [7:0] s;
    unique case (d)
      4'd0:    s = 8'hC0;
      4'd1:    s = 8'hF9;
      4'd2:    s = 8'hA4;
      4'd3:    s = 8'hB0;
      4'd4:    s = 8'h99;
      4'd5:    s = 8'h92;
      4'd6:    s = 8'h82;
      4'd7:    s = 8'hF8;
      4'd8:    s = 8'h80;
      4'd9:    s = 8'h90;
      default: s = 8'hFF;
    endcase
    return s;
  endfunction

  // digit select byte
  function automatic logic [7:0] sel_of(input pos_t p);
    logic [7:0] s;
    unique case (p)
      2'd0:    s = 8'hF1;
      2'd1:    s = 8'hF2;
      2'd2:    s = 8'hF4;
      default: s = 8'hF8;
    endcase
    return s;
  endfunction

endpackage

### sv/ssw_div10.sv
module ssw_div10 (
  input  logic             clk,
  input  ssw_pkg::val_t    val,
  output ssw_pkg::quot_t   quot_r,
  output ssw_pkg::digit_t  digit_r
);
  import ssw_pkg::*;

  logic [ProdW-1:0] prod;
  quot_t            quot_nxt;
  logic [ValW-1:0]  times10;
  logic [ValW-1:0]  rem;

  // reciprocal multiply, exact for values below 10000
  assign prod     = ProdW'(val) * ProdW'(RECIP_10);
  assign quot_nxt = prod[RecipSh +: QuotW];
  assign times10  = (ValW'(quot_nxt) << 3) + (ValW'(quot_nxt) << 1);
  assign rem      = val - times10;

  always_ff @(posedge clk) begin
    quot_r  <= quot_nxt;
    digit_r <= rem[DigitW-1:0];
  end

endmodule

### sv/ssw_shifter.sv
module ssw_shifter (
  input  logic                clk,
  input  logic                rst_n,
  input  ssw_pkg::ssw_frame_t frame,
  output logic                busy,
  output logic                out_tvalid,
  input  logic                out_tready,
  output logic [7:0]          out_tdata,   // [0] serial_bit, [7:1] zero
  output logic [2:0]          out_tuser,   // [0] latch_after, [2:1] digit_position
  output logic                out_tlast    // last_bit
);
  import ssw_pkg::*;

  logic [FrameW-1:0]  sh_r;
  logic [BitCntW-1:0] cnt_r;
  logic               busy_r;
  pos_t               pos_r;
  logic               last_r;
  logic               frame_end;

  assign frame_end  = (cnt_r == BIT_LAST);
  assign busy       = busy_r;
  assign out_tvalid = busy_r;
  assign out_tdata  = {7'd0, sh_r[FrameW-1]};
  assign out_tuser  = {pos_r, frame_end};
  assign out_tlast  = last_r & frame_end;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else if (!busy_r) begin
      if (frame.load) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end
    end else if (out_tready) begin
      cnt_r <= cnt_r + 1'b1;
      if (frame_end) begin
        busy_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!busy_r && frame.load) begin
      sh_r   <= frame.bits;
      pos_r  <= frame.pos;
      last_r <= frame.last;
    end else if (busy_r && out_tready) begin
      sh_r <= {sh_r[FrameW-2:0], 1'b0};
    end
  end

endmodule

### sv/seven_segment_shift_writer.sv
// accepts one number when idle; 0..9999 gives one 16-bit frame per digit, units first,
// one bit per cycle on the result channel while out_tready is high, leading zeros suppressed
// the first bit is valid once the number is registered, divided and loaded into the shifter;
// each digit shifts out its 16 frame bits, then the sequencer hands over the next frame;
// ready again once the last frame is sent; out-of-range numbers are dropped, ready next cycle
// synchronous active-low reset returns the sequencer to idle and empties the shifter
module seven_segment_shift_writer (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,    // [15:0] number (signed)
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [7:0]  out_tdata,   // [0] serial_bit, [7:1] zero
  output logic [2:0]  out_tuser,   // [0] latch_after, [2:1] digit_position
  output logic        out_tlast    // last_bit
);
  import ssw_pkg::*;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_DIV  = 2'd1;
  localparam logic [1:0] S_LOAD = 2'd2;
  localparam logic [1:0] S_SEND = 2'd3;

  logic [1:0]  state_r, state_nxt;
  val_t        val_r, val_nxt;
  pos_t        pos_r, pos_nxt;
  logic        last_r, last_nxt;
  quot_t       quot;
  digit_t      digit;
  ssw_frame_t  frame;
  logic        busy;
  logic        in_range;
  logic        accept;

  assign in_tready = (state_r == S_IDLE);
  assign accept    = in_tvalid & in_tready;
  assign in_range  = !in_tdata[NumW-1] && (in_tdata <= NUM_MAX);

  ssw_div10 u_div (
    .clk     (clk),
    .val     (val_r),
    .quot_r  (quot),
    .digit_r (digit)
  );

  always_comb begin
    frame.load = (state_r == S_LOAD);
    frame.bits = {seg_of(digit), sel_of(pos_r)};
    frame.pos  = pos_r;
    frame.last = (quot == '0);
  end

  ssw_shifter u_shift (
    .clk        (clk),
    .rst_n      (rst_n),
    .frame      (frame),
    .busy       (busy),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  always_comb begin
    state_nxt = state_r;
    val_nxt   = val_r;
    pos_nxt   = pos_r;
    last_nxt  = last_r;
    unique case (state_r)
      S_IDLE: begin
        if (accept && in_range) begin
          val_nxt   = in_tdata[ValW-1:0];
          pos_nxt   = POS_UNITS;
          state_nxt = S_DIV;
        end
      end
      S_DIV: begin
        state_nxt = S_LOAD;
      end
      S_LOAD: begin
        // quotient feeds the next digit while this frame shifts out
        val_nxt   = ValW'(quot);
        last_nxt  = (quot == '0);
        state_nxt = S_SEND;
      end
      S_SEND: begin
        if (!busy) begin
          if (last_r) begin
            state_nxt = S_IDLE;
          end else begin
            pos_nxt   = pos_r - 1'b1;
            state_nxt = S_LOAD;
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    val_r  <= val_nxt;
    pos_r  <= pos_nxt;
    last_r <= last_nxt;
  end

endmodule
